FILE: sv/hca_pkg.sv
// Shared types and constants of the hashed channel allocator.
`timescale 1ns / 1ps

package hca_pkg;

    // Fixed field widths of the request and response beats
    localparam int ID_W   = 64;
    localparam int CHAN_W = 4;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // Multiplicative hash: start slot comes from bits 36..32 of id * HASH_MULT
    localparam logic [31:0] HASH_MULT  = 32'd2654435769;
    localparam int          HASH_SHIFT = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_BUSY     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_SEED,
        S_PROBE,
        S_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic release_ch;
        logic reject;
        logic seed;
        logic step;
        logic grant;
        logic give_up;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_release;
        logic id_zero;
        logic chan_valid;
        logic slot_free;
        logic last_try;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: sv/hca_req_if.sv
// Request channel: valid/ready handshake with opcode, thread id and channel.
`timescale 1ns / 1ps

interface hca_req_if;
    import hca_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ID_W-1:0]   thread_id;
    logic [CHAN_W-1:0] channel_in;

    modport source (output valid, output opcode, output thread_id, output channel_in,
                    input ready);
    modport sink   (input valid, input opcode, input thread_id, input channel_in,
                    output ready);
endinterface

FILE: sv/hca_rsp_if.sv
// Response channel: valid/ready handshake with channel number and status.
`timescale 1ns / 1ps

interface hca_rsp_if;
    import hca_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel_out;
    logic [STAT_W-1:0] status;

    modport source (output valid, output channel_out, output status, input ready);
    modport sink   (input valid, input channel_out, input status, output ready);
endinterface

FILE: sv/hca_ctrl.sv
// Controller state machine of the hashed channel allocator.
`timescale 1ns / 1ps

module hca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hca_pkg::t_dp_stat i_stat,
    output hca_pkg::t_dp_cmd  o_cmd
);
    import hca_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (i_stat.is_release || i_stat.id_zero) n_state = S_FINISH;
                else n_state = S_SEED;
            end
            S_SEED: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.slot_free || i_stat.last_try) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_HASH: begin
                // Release and zero-id requests resolve without probing
                if (i_stat.is_release) begin
                    o_cmd.release_ch = i_stat.chan_valid;
                    o_cmd.reject     = !i_stat.chan_valid;
                end else begin
                    o_cmd.reject = i_stat.id_zero;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
            end
            S_PROBE: begin
                if (i_stat.slot_free) begin
                    o_cmd.grant = 1'b1;
                end else if (i_stat.last_try) begin
                    o_cmd.give_up = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/hca_dp.sv
// Datapath: request capture, hash, probe pointer, occupancy table, result register.
`timescale 1ns / 1ps

module hca_dp #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hca_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                       i_opcode,
    input  logic [hca_pkg::ID_W-1:0]   i_thread_id,
    input  logic [hca_pkg::CHAN_W-1:0] i_channel_in,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [hca_pkg::CHAN_W-1:0] o_channel_out,
    output logic [hca_pkg::STAT_W-1:0] o_status,
    input  hca_pkg::t_dp_cmd           i_cmd,
    output hca_pkg::t_dp_stat          o_stat
);
    import hca_pkg::*;

    localparam int LIM_W = CNT_W + 4;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_CHANNELS);

    // Channel count register and captured request
    logic [CNT_W-1:0]  r_count;
    logic              r_opcode;
    logic [ID_W-1:0]   r_id;
    logic [CHAN_W-1:0] r_chan_in;

    // Hash partial products
    logic [2*32-1:0]    prod_lo;
    logic [2*CNT_W-1:0] prod_hi;
    logic [CNT_W-1:0]   r_hash_lo;
    logic [CNT_W-1:0]   r_hash_hi;
    logic [CNT_W-1:0]   hash;

    // Probe pointer and try counter
    logic [CNT_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_tries;
    logic [CNT_W:0]     slot_inc;
    logic [CNT_W-1:0]   slot_next;

    // Occupancy: an owner is never read back, so one busy flag per channel suffices
    logic [MAX_CHANNELS-1:0] r_busy;
    logic [MAX_CHANNELS-1:0] n_busy;
    logic                    slot_free;

    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] mask;

    // Pending result and output beat
    logic [CHAN_W-1:0] r_res_chan;
    t_status           r_res_status;
    logic              r_out_valid;
    logic [CHAN_W-1:0] r_out_chan;
    t_status           r_out_status;

    // Effective count: zero reads as one, saturate at the table size
    always_comb begin
        if (r_count == '0) begin
            eff = CNT_W'(1);
        end else if ({4'b0, r_count} > MAX_LIM) begin
            eff = CNT_W'(MAX_CHANNELS);
        end else begin
            eff = r_count;
        end
        mask = eff - CNT_W'(1);
    end

    // Bits 36..32 of the product: low word times constant, plus the
    // low bits of the next id bits times the constant
    assign prod_lo = {32'b0, r_id[31:0]} * {32'b0, HASH_MULT};
    assign prod_hi = {{CNT_W{1'b0}}, r_id[HASH_SHIFT +: CNT_W]} *
                     {{CNT_W{1'b0}}, HASH_MULT[CNT_W-1:0]};
    assign hash    = r_hash_lo + r_hash_hi;

    // Advance with wrap at the effective count
    assign slot_inc  = {1'b0, r_slot} + (CNT_W+1)'(1);
    assign slot_next = (slot_inc >= {1'b0, eff}) ? '0 : slot_inc[CNT_W-1:0];

    // Look up the probed slot; slots beyond the table never count as free
    always_comb begin
        slot_free = 1'b0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (int'(r_slot) == i) slot_free = !r_busy[i];
        end
    end

    // Claim on grant, clear on release
    always_comb begin
        n_busy = r_busy;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (i_cmd.grant && int'(r_slot) == i) n_busy[i] = 1'b1;
            if (i_cmd.release_ch && int'(r_chan_in) == i) n_busy[i] = 1'b0;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat            = '0;
        o_stat.is_release = (r_opcode == OP_RELEASE);
        o_stat.id_zero    = (r_id == '0);
        o_stat.chan_valid = ({1'b0, r_chan_in} < eff);
        o_stat.slot_free  = slot_free;
        o_stat.last_try   = (r_tries == mask);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Control state: count, occupancy, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            r_busy <= n_busy;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode  <= i_opcode;
            r_id      <= i_thread_id;
            r_chan_in <= i_channel_in;
        end
        r_hash_lo <= prod_lo[HASH_SHIFT +: CNT_W];
        r_hash_hi <= prod_hi[CNT_W-1:0];
        if (i_cmd.seed) begin
            r_slot  <= hash & mask;
            r_tries <= '0;
        end else if (i_cmd.step) begin
            r_slot  <= slot_next;
            r_tries <= r_tries + CNT_W'(1);
        end
        if (i_cmd.release_ch) begin
            r_res_chan   <= r_chan_in;
            r_res_status <= ST_RELEASED;
        end else if (i_cmd.reject) begin
            r_res_chan   <= '0;
            r_res_status <= ST_INVALID;
        end else if (i_cmd.grant) begin
            r_res_chan   <= r_slot[CHAN_W-1:0];
            r_res_status <= ST_GRANTED;
        end else if (i_cmd.give_up) begin
            r_res_chan   <= '0;
            r_res_status <= ST_BUSY;
        end
        if (i_cmd.load_out) begin
            r_out_chan   <= r_res_chan;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_chan;
    assign o_status      = r_out_status;

    // The probe pointer stays inside the channels in use
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step || i_cmd.grant) |-> (r_slot < eff))
        else $error("probe slot outside the channel count");

    // A result never overwrites a beat that has not been taken
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output beat overwritten");

    // A grant records a granted result on the probed slot
    a_grant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.grant |=> (r_res_status == ST_GRANTED &&
                         r_res_chan == $past(r_slot[CHAN_W-1:0])))
        else $error("grant result mismatch");

endmodule

FILE: sv/hashed_channel_allocator.sv
// Top level of the hashed channel allocator: controller plus datapath.
`timescale 1ns / 1ps
//
// Hands out channels from a table of MAX_CHANNELS by thread id.
// i_req carries one request beat: opcode (acquire or release), a 64-bit
// thread id and, for release, a channel number. o_rsp returns one beat per
// request: the channel and a status (granted, busy, released, invalid).
// i_cfg_we / i_cfg_wdata write the channel count; write it only while idle.
// An acquire hashes the id (id * 2654435769, bits 36..32, masked to the
// count) and probes one slot per clock, wrapping at the count, until a
// free slot is found or every slot has been tried.
// An acquire passes the hash, seed and probe states and probes from one slot
// up to the count; a release or an invalid request goes from the hash state
// straight to the finish state. One request is in flight at a time; the probe
// loop sets the rate at which acquires are served.
// Reset (synchronous, active low) frees every channel, sets the count to 16
// and empties the output register. The response sits in an output register,
// so the next request is taken while it waits; a stalled receiver holds the
// beat and keeps the following result, and any later request, waiting.
//
module hashed_channel_allocator #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hca_pkg::CNT_W-1:0] i_cfg_wdata,
    hca_req_if.sink                   i_req,
    hca_rsp_if.source                 o_rsp
);
    import hca_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    hca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hca_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_req.opcode),
        .i_thread_id   (i_req.thread_id),
        .i_channel_in  (i_req.channel_in),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_channel_out (o_rsp.channel_out),
        .o_status      (o_rsp.status),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    assign i_req.ready = in_ready;

endmodule
